FILE: hw/rtl/vlqd_pkg.sv
// ----------------------------------------------------------------------------
// vlqd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package vlqd_pkg;

    localparam int LEN_W      = 32;
    localparam int CNT_W      = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;
    localparam int VALUE_BITS = 7;
    localparam logic [7:0] VALUE_MASK = 8'((1 << VALUE_BITS) - 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [0:0] REG_IDX_MSG_EXP = 1'b0;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             is_empty;
        logic             last_in_message;
        logic [31:0]      message_length;
        logic [CNT_W-1:0] message_index;
        logic             last_message;
    } result_t;

endpackage

FILE: hw/rtl/vlq_length_prefix_deframer.sv
// A result is queued as its byte transfers; the queue head drives the ports.
// Throughput: one byte per cycle while full is low; full rises only when the 4-entry result
// queue is full and pop is held low.
// Reset: rst_n clears the decoder state, the message counter, the queue and
// messages_expected; with messages_expected at zero every byte is dropped.
// ----------------------------------------------------------------------------
// vlq_length_prefix_deframer
// Top level: configuration register, decoder front and result queue.
// ----------------------------------------------------------------------------
module vlq_length_prefix_deframer
    import vlqd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        in_byte,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        payload_byte,
    output logic              is_empty,
    output logic              last_in_message,
    output logic [31:0]       message_length,
    output logic [CNT_W-1:0]  message_index,
    output logic              last_message
);

    logic [CNT_W-1:0] msg_exp_reg;
    logic             cfg_wr;
    logic             byte_valid;
    logic             res_valid;
    result_t          res;
    result_t          head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_IDX_MSG_EXP);
    assign prdata = (paddr[2:2] == REG_IDX_MSG_EXP) ? DATA_W'(msg_exp_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_exp_reg <= '0;
        end
        else if (cfg_wr)
        begin
            msg_exp_reg <= CNT_W'(pwdata);
        end
    end

    assign byte_valid = push && !full;

    vlqd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .in_byte           (in_byte),
        .messages_expected (msg_exp_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    vlqd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .rd_en   (pop),
        .empty   (empty),
        .rd_data (head)
    );

    assign payload_byte    = head.payload_byte;
    assign is_empty        = head.is_empty;
    assign last_in_message = head.last_in_message;
    assign message_length  = head.message_length;
    assign message_index   = head.message_index;
    assign last_message    = head.last_message;

endmodule

FILE: hw/rtl/vlqd_front.sv
// ----------------------------------------------------------------------------
// vlqd_front
// Prefix decoder and message tracker: classifies each byte and builds results.
// ----------------------------------------------------------------------------
module vlqd_front
    import vlqd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       in_byte,
    input  logic [CNT_W-1:0] messages_expected,
    output logic             res_valid,
    output result_t          res
);

    localparam logic PH_PREFIX  = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    logic             phase_reg, phase_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             done;
    logic [LEN_W-1:0] acc_shift;
    logic [LEN_W-1:0] rem_dec;
    logic             last_msg;

    assign done      = (cnt_reg >= messages_expected);
    assign acc_shift = {acc_reg[LEN_W-8:0], in_byte[VALUE_BITS-1:0]};
    assign rem_dec   = rem_reg - LEN_W'(1);
    assign last_msg  = ((cnt_reg + CNT_W'(1)) == messages_expected);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;
        res.payload_byte    = 8'd0;
        res.is_empty        = 1'b0;
        res.last_in_message = 1'b0;
        res.message_length  = 32'(acc_reg);
        res.message_index   = cnt_reg;
        res.last_message    = last_msg;
        if (byte_valid && !done)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    acc_next = acc_shift;
                    if (!in_byte[7])
                    begin
                        if (acc_shift == '0)
                        begin
                            res_valid           = 1'b1;
                            res.is_empty        = 1'b1;
                            res.last_in_message = 1'b1;
                            res.message_length  = 32'd0;
                            cnt_next            = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            rem_next   = acc_shift;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    rem_next            = rem_dec;
                    res_valid           = 1'b1;
                    res.payload_byte    = in_byte;
                    res.last_in_message = (rem_dec == '0);
                    if (rem_dec == '0)
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        phase_next = PH_PREFIX;
                        acc_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_PREFIX;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            acc_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/vlqd_fifo.sv
// ----------------------------------------------------------------------------
// vlqd_fifo
// Short result queue between the decoder and the result port.
// ----------------------------------------------------------------------------
module vlqd_fifo
    import vlqd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output logic    empty,
    output result_t rd_data
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        count_next = count_reg + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule
